[rtl/core/kwm_pkg.sv]
// Shared types and constants of the k-way sorted merge unit.
package kwm_pkg;

  // Default configuration of the merge unit.
  localparam int LISTS_DEF       = 8;
  localparam int QUEUE_DEPTH_DEF = 8;

  // The list number field is this many bits wide, so only eight queues can be addressed.
  localparam int LIST_ID_W = 3;
  localparam int VALUE_W   = 32;

  // Stream packing.
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 2;

  // Item operation codes, carried in in_tuser.
  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } kwm_op_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_SCAN,
    ST_DRAIN,
    ST_TAKE,
    ST_FINISH
  } kwm_state_t;

endpackage

[rtl/core/k_way_sorted_merge_unit.sv]
// Top level of the k-way sorted merge unit: queues, head scanner and output register.
//
// The unit holds a set of first-in first-out queues of signed 32-bit values. Each
// item on the input stream is either a push (in_tuser = 0), which appends the value
// to the queue named by the list number, or a pop (in_tuser = 1), which removes the
// smallest head value over all non-empty queues, the lowest queue number winning a
// tie. Every item yields exactly one result item on the output stream, carrying the
// value and queue of a pop, a valid flag and an overflow flag for a push that found
// its queue full. Queue numbers at or above the number of queues are ignored.
// The unit takes one item at a time. A push to an existing queue passes through the push and finish
// states on its way to the output register; a pop steps through the scan, drain, take and finish
// states, take being skipped when no queue holds an item. The scan visits the NQ queues one after
// another, where NQ is the number of addressable queues (LISTS, at most 8), as a single signed
// comparator looks at one queue head per cycle as the queue store's read port delivers it. The next
// item is accepted the cycle after the result has been handed to the output register.
// Reset empties all queues at once and clears the output; the entry store itself
// needs no clearing pass, as only written entries are ever used. When the receiver
// stalls, the result waits in the output register and the unit holds its finished
// result until the register frees, so nothing is lost or repeated.
module k_way_sorted_merge_unit
  import kwm_pkg::*;
#(
  parameter int LISTS       = LISTS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input items.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // list_id[2:0], value[34:3], zero pad
  input  logic                   in_tuser,   // opcode[0]
  // Result items.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // result_value[31:0], source_list[34:32], pad
  output logic [OUT_TUSER_W-1:0] out_tuser   // valid_res[0], overflow[1]
);

  // Queues beyond eight cannot be named by a push, so they are never built.
  localparam int NQ     = (LISTS < 8) ? LISTS : 8;
  localparam int QIDX_W = $clog2(NQ);
  localparam int SLOT_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [QIDX_W-1:0]    LAST_Q   = QIDX_W'(NQ - 1);
  localparam logic [LIST_ID_W:0]   NQ_L     = (LIST_ID_W + 1)'(NQ);
  localparam logic [CNT_W-1:0]     FULL_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [SLOT_W:0]      DEPTH_S  = (SLOT_W + 1)'(QUEUE_DEPTH);
  localparam logic [SLOT_W-1:0]    LAST_SLT = SLOT_W'(QUEUE_DEPTH - 1);

  // Input fields.
  logic [LIST_ID_W-1:0] in_list;
  logic [VALUE_W-1:0]   in_value;
  kwm_op_t              in_op;

  assign in_list  = in_tdata[LIST_ID_W-1:0];
  assign in_value = in_tdata[LIST_ID_W +: VALUE_W];
  assign in_op    = kwm_op_t'(in_tuser);

  // Sequencer and queue state.
  kwm_state_t          state_r, state_nxt;
  logic [QIDX_W-1:0]   q_idx_r, q_idx_nxt;
  logic [SLOT_W-1:0]   head_r [NQ];
  logic [SLOT_W-1:0]   head_nxt [NQ];
  logic [CNT_W-1:0]    fill_r [NQ];
  logic [CNT_W-1:0]    fill_nxt [NQ];

  // Scan pipeline: the head read issued for one queue is registered and compared in the cycle after.
  logic                rd_ok_r, rd_ok_nxt;
  logic [QIDX_W-1:0]   rd_q_r;
  logic [VALUE_W-1:0]  rd_data_r;
  logic                found_r, found_nxt;
  logic [QIDX_W-1:0]   best_q_r, best_q_nxt;
  logic [VALUE_W-1:0]  best_val_r, best_val_nxt;

  // Push value and pending result.
  logic [VALUE_W-1:0]   val_r, val_nxt;
  logic [VALUE_W-1:0]   res_value_r, res_value_nxt;
  logic [LIST_ID_W-1:0] res_src_r, res_src_nxt;
  logic                 res_valid_r, res_valid_nxt;
  logic                 res_ovf_r, res_ovf_nxt;

  // Output register.
  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [OUT_TUSER_W-1:0] out_tuser_r, out_tuser_nxt;

  // Entry store, one row per queue.
  logic [VALUE_W-1:0] entry_mem [NQ][QUEUE_DEPTH];
  logic               mem_we;
  logic [SLOT_W-1:0]  wr_slot;

  // Single index into the head and fill registers.
  logic [SLOT_W-1:0]  head_sel;
  logic [CNT_W-1:0]   fill_sel;
  logic [SLOT_W:0]    slot_sum;

  assign head_sel = head_r[q_idx_r];
  assign fill_sel = fill_r[q_idx_r];
  assign slot_sum = (SLOT_W + 1)'(head_sel) + (SLOT_W + 1)'(fill_sel);
  assign wr_slot  = (slot_sum >= DEPTH_S) ? SLOT_W'(slot_sum - DEPTH_S) : slot_sum[SLOT_W-1:0];

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  always_comb begin
    state_nxt      = state_r;
    q_idx_nxt      = q_idx_r;
    head_nxt       = head_r;
    fill_nxt       = fill_r;
    rd_ok_nxt      = 1'b0;
    found_nxt      = found_r;
    best_q_nxt     = best_q_r;
    best_val_nxt   = best_val_r;
    val_nxt        = val_r;
    res_value_nxt  = res_value_r;
    res_src_nxt    = res_src_r;
    res_valid_nxt  = res_valid_r;
    res_ovf_nxt    = res_ovf_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    mem_we         = 1'b0;

    // Compare stage: a non-empty head replaces the best only when strictly
    // smaller, so the earlier (lower numbered) queue keeps a tie.
    if (rd_ok_r && (!found_r || ($signed(rd_data_r) < $signed(best_val_r)))) begin
      found_nxt    = 1'b1;
      best_q_nxt   = rd_q_r;
      best_val_nxt = rd_data_r;
    end

    unique case (state_r)
      ST_IDLE: begin
        res_value_nxt = '0;
        res_src_nxt   = '0;
        res_valid_nxt = 1'b0;
        res_ovf_nxt   = 1'b0;
        if (in_tvalid) begin
          if (in_op == OP_POP) begin
            q_idx_nxt = '0;
            found_nxt = 1'b0;
            state_nxt = ST_SCAN;
          end else if ({1'b0, in_list} >= NQ_L) begin
            state_nxt = ST_FINISH;
          end else begin
            q_idx_nxt = in_list[QIDX_W-1:0];
            val_nxt   = in_value;
            state_nxt = ST_PUSH;
          end
        end
      end
      ST_PUSH: begin
        if (fill_sel == FULL_CNT) begin
          res_ovf_nxt = 1'b1;
        end else begin
          mem_we             = 1'b1;
          fill_nxt[q_idx_r]  = fill_sel + CNT_W'(1);
        end
        state_nxt = ST_FINISH;
      end
      ST_SCAN: begin
        rd_ok_nxt = (fill_sel != '0);
        if (q_idx_r == LAST_Q) begin
          state_nxt = ST_DRAIN;
        end else begin
          q_idx_nxt = q_idx_r + QIDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (found_nxt) begin
          q_idx_nxt = best_q_nxt;
          state_nxt = ST_TAKE;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_TAKE: begin
        head_nxt[q_idx_r] = (head_sel == LAST_SLT) ? '0 : head_sel + SLOT_W'(1);
        fill_nxt[q_idx_r] = fill_sel - CNT_W'(1);
        res_value_nxt     = best_val_r;
        res_src_nxt       = LIST_ID_W'(best_q_r);
        res_valid_nxt     = 1'b1;
        state_nxt         = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = OUT_TDATA_W'({res_src_r, res_value_r});
          out_tuser_nxt  = {res_ovf_r, res_valid_r};
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rd_ok_r      <= 1'b0;
      found_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < NQ; i++) begin
        head_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      rd_ok_r      <= rd_ok_nxt;
      found_r      <= found_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      head_r       <= head_nxt;
      fill_r       <= fill_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    q_idx_r     <= q_idx_nxt;
    rd_q_r      <= q_idx_r;
    best_q_r    <= best_q_nxt;
    best_val_r  <= best_val_nxt;
    val_r       <= val_nxt;
    res_value_r <= res_value_nxt;
    res_src_r   <= res_src_nxt;
    res_valid_r <= res_valid_nxt;
    res_ovf_r   <= res_ovf_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  // Entry store: one write port, one registered read port at the selected head.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[q_idx_r][wr_slot] <= val_r;
    end
    rd_data_r <= entry_mem[q_idx_r][head_sel];
  end

endmodule
